[design/fbfs_pkg.sv]
// Shared types and constants of the free block fit selector.
`default_nettype none

package fbfs_pkg;

  // Fixed widths of the table index fields and the list length.
  localparam int IDX_W = 6;
  localparam int LEN_W = 7;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_HOLD = 2'd2
  } scan_state_t;

endpackage

`default_nettype wire

[design/fbfs_req_if.sv]
// Input item channel: table writes and fit queries.
`default_nettype none

interface fbfs_req_if #(
  parameter int ADDR_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [fbfs_pkg::IDX_W-1:0]   entry_index;
  logic [ADDR_BITS-1:0]         entry_start;
  logic [ADDR_BITS:0]           entry_size;
  logic                         entry_is_free;
  logic                         list_end;
  logic [ADDR_BITS:0]           request_size;

  modport source (
    output valid, action, entry_index, entry_start, entry_size, entry_is_free,
           list_end, request_size,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, entry_start, entry_size, entry_is_free,
           list_end, request_size,
    output ready
  );
endinterface

`default_nettype wire

[design/fbfs_rsp_if.sv]
// Result item channel: outcome of one fit query.
`default_nettype none

interface fbfs_rsp_if #(
  parameter int ADDR_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [fbfs_pkg::IDX_W-1:0]   chosen_index;
  logic [ADDR_BITS-1:0]         chosen_start;
  logic [ADDR_BITS:0]           chosen_size;

  modport source (
    output valid, found, chosen_index, chosen_start, chosen_size,
    input  ready
  );
  modport sink (
    input  valid, found, chosen_index, chosen_start, chosen_size,
    output ready
  );
endinterface

`default_nettype wire

[design/fbfs_cfg_if.sv]
// Configuration write channel carrying the fit policy register.
`default_nettype none

interface fbfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

`default_nettype wire

[design/fbfs_table_mem.sv]
// Block table memory: one write port, one read port with registered data.
`default_nettype none

module fbfs_table_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 34
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/fbfs_scan.sv]
// Scan engine: walks the table one entry per cycle and keeps the running pick.
`default_nettype none

module fbfs_scan #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ADDR_BITS:0]            start_req_size,
  input  wire fbfs_pkg::policy_t             policy,
  input  wire logic [fbfs_pkg::LEN_W-1:0]    list_length,
  output logic [$clog2(MAX_BLOCKS)-1:0]      rd_addr,
  input  wire logic [2*ADDR_BITS+1:0]        rd_data,
  output logic                               idle,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic                               res_found,
  output logic [fbfs_pkg::IDX_W-1:0]         res_index,
  output logic [ADDR_BITS-1:0]               res_start,
  output logic [ADDR_BITS:0]                 res_size
);

  localparam int IW = $clog2(MAX_BLOCKS);

  fbfs_pkg::scan_state_t state, state_next;

  logic [fbfs_pkg::LEN_W-1:0] issue_idx;
  logic [fbfs_pkg::LEN_W-1:0] rd_idx;
  logic                       rd_vld;
  logic                       hit;
  logic                       pass2;
  logic                       armed;
  logic [ADDR_BITS-1:0]       next_fit_start;
  logic [ADDR_BITS:0]         req_size;
  logic [fbfs_pkg::IDX_W-1:0] pick_idx;
  logic [ADDR_BITS-1:0]       pick_start;
  logic [ADDR_BITS:0]         pick_size;

  logic                       issue_go;
  logic                       pass_end;
  logic                       restart;
  logic                       deliver;
  logic                       ent_free;
  logic [ADDR_BITS:0]         ent_size;
  logic [ADDR_BITS-1:0]       ent_start;
  logic                       fits;
  logic                       past_mark;
  logic                       take;

  assign ent_free  = rd_data[2*ADDR_BITS+1];
  assign ent_size  = rd_data[2*ADDR_BITS:ADDR_BITS];
  assign ent_start = rd_data[ADDR_BITS-1:0];
  assign fits      = ent_free && (ent_size >= req_size);
  assign past_mark = ent_free && (ent_start >= next_fit_start);

  assign rd_addr = IW'(issue_idx);

  // Candidate selection for the entry whose data has just come back.
  always_comb begin
    take = 1'b0;
    if (rd_vld) begin
      unique case (policy)
        fbfs_pkg::POL_FIRST: take = fits && !hit;
        fbfs_pkg::POL_BEST:  take = fits && (!hit || ent_size < pick_size);
        fbfs_pkg::POL_WORST: take = fits && (!hit || ent_size > pick_size);
        fbfs_pkg::POL_NEXT:  take = fits && !hit && (armed || past_mark);
        default:             take = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    issue_go   = (state == fbfs_pkg::S_SCAN) && (issue_idx < list_length);
    pass_end   = (state == fbfs_pkg::S_SCAN) && !issue_go && !rd_vld;
    restart    = pass_end && (policy == fbfs_pkg::POL_NEXT) && !hit && !pass2;
    deliver    = (state == fbfs_pkg::S_HOLD) && res_ready;
    idle       = (state == fbfs_pkg::S_IDLE);
    res_valid  = (state == fbfs_pkg::S_HOLD);
    unique case (state)
      fbfs_pkg::S_IDLE: begin
        if (start) begin
          state_next = fbfs_pkg::S_SCAN;
        end
      end
      fbfs_pkg::S_SCAN: begin
        if (pass_end && !restart) begin
          state_next = fbfs_pkg::S_HOLD;
        end
      end
      fbfs_pkg::S_HOLD: begin
        if (res_ready) begin
          state_next = fbfs_pkg::S_IDLE;
        end
      end
      default: state_next = fbfs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbfs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx      <= '0;
      rd_vld         <= 1'b0;
      hit            <= 1'b0;
      pass2          <= 1'b0;
      armed          <= 1'b0;
      next_fit_start <= '0;
    end else begin
      rd_vld <= issue_go;
      if (start && idle) begin
        issue_idx <= '0;
        hit       <= 1'b0;
        pass2     <= 1'b0;
        armed     <= 1'b0;
      end else if (issue_go) begin
        issue_idx <= issue_idx + 1'b1;
      end else if (restart) begin
        // Second pass of next fit runs from the head with the mark already met.
        issue_idx <= '0;
        pass2     <= 1'b1;
        armed     <= 1'b1;
      end
      if (rd_vld) begin
        if (past_mark) begin
          armed <= 1'b1;
        end
        if (take) begin
          hit <= 1'b1;
        end
      end
      if (deliver && policy == fbfs_pkg::POL_NEXT) begin
        next_fit_start <= hit ? pick_start : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && idle) begin
      req_size <= start_req_size;
    end
    if (issue_go) begin
      rd_idx <= issue_idx;
    end
    if (take) begin
      pick_idx   <= fbfs_pkg::IDX_W'(rd_idx);
      pick_start <= ent_start;
      pick_size  <= ent_size;
    end
  end

  assign res_found = hit;
  assign res_index = hit ? pick_idx : '0;
  assign res_start = hit ? pick_start : '0;
  assign res_size  = hit ? pick_size : '0;

endmodule

`default_nettype wire

[design/free_block_fit_selector.sv]
// Top level of the free block fit selector.
//
// The block holds an address-ordered table of memory blocks (start, size,
// free mark) in a single synchronous memory. A write item loads one entry and,
// when it carries the end mark, sets the list length to its index plus one;
// writes at or beyond MAX_BLOCKS are dropped. A query item starts a scan that
// reads one table entry per cycle through the memory's single read port;
// under next fit, a second pass from the head follows when the first pass
// misses. Only one query is worked on at a time, but the next item is taken
// as soon as the scan has handed its result to the output register, even
// while that result is still waiting to be taken. Table entries hold no
// reset value, so no clearing pass is needed; an entry inside the list must
// be written before it is queried. The fit policy register may be written
// only while the block is idle.
`default_nettype none

module free_block_fit_selector #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  fbfs_req_if.sink   req,
  fbfs_rsp_if.source rsp,
  fbfs_cfg_if.sink   cfg
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int EW = 2 * ADDR_BITS + 2;

  fbfs_pkg::policy_t          fit_policy;
  logic [fbfs_pkg::LEN_W-1:0] list_length;

  logic                 accept;
  logic                 wr_en;
  logic [IW-1:0]        rd_addr;
  logic [EW-1:0]        rd_data;
  logic                 scan_idle;
  logic                 res_valid;
  logic                 res_ready;
  logic                 res_found;
  logic [fbfs_pkg::IDX_W-1:0] res_index;
  logic [ADDR_BITS-1:0] res_start;
  logic [ADDR_BITS:0]   res_size;

  // Items are taken whenever the scan engine is free.
  assign req.ready = scan_idle;
  assign accept    = req.valid && req.ready;

  // A write lands in the table only when its index lies inside the table.
  assign wr_en = accept && (fbfs_pkg::action_t'(req.action) == fbfs_pkg::ACT_WRITE)
                 && (32'(req.entry_index) < MAX_BLOCKS);

  // The policy register is always ready to be written.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= fbfs_pkg::POL_FIRST;
      list_length <= '0;
    end else begin
      if (cfg.valid) begin
        fit_policy <= fbfs_pkg::policy_t'(cfg.data);
      end
      if (wr_en && req.list_end) begin
        list_length <= fbfs_pkg::LEN_W'(req.entry_index) + 1'b1;
      end
    end
  end

  fbfs_table_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (EW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (IW'(req.entry_index)),
    .wdata ({req.entry_is_free, req.entry_size, req.entry_start}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  fbfs_scan #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .start          (accept && (fbfs_pkg::action_t'(req.action) == fbfs_pkg::ACT_QUERY)),
    .start_req_size (req.request_size),
    .policy         (fit_policy),
    .list_length    (list_length),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .idle           (scan_idle),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_found      (res_found),
    .res_index      (res_index),
    .res_start      (res_start),
    .res_size       (res_size)
  );

  // Output register: it parts the scan from the consumer, so the scan can
  // hand over its result and go back to idle while the item waits here.
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.found        <= res_found;
      rsp.chosen_index <= res_index;
      rsp.chosen_start <= res_start;
      rsp.chosen_size  <= res_size;
    end
  end

endmodule

`default_nettype wire
